/* design/mlr_pkg.sv */
`timescale 1ns / 1ps

package mlr_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int COLOR_BITS     = 24;

    typedef enum logic {
        REQ_START   = 1'b0,
        REQ_ADVANCE = 1'b1
    } t_req_type;

endpackage

/* design/mlr_if.sv */
`timescale 1ns / 1ps

// request word: a new line or a step along the current one
interface mlr_req_if #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
);
    logic                                valid;
    logic                                ready;
    logic                                req_type;
    logic signed [COORD_BITS-1:0]        x_start;
    logic signed [COORD_BITS-1:0]        y_start;
    logic signed [COORD_BITS-1:0]        x_end;
    logic signed [COORD_BITS-1:0]        y_end;
    logic        [mlr_pkg::COLOR_BITS-1:0] pixel_color;

    modport source (
        output valid, req_type, x_start, y_start, x_end, y_end, pixel_color,
        input  ready
    );
    modport sink (
        input  valid, req_type, x_start, y_start, x_end, y_end, pixel_color,
        output ready
    );
endinterface

// pixel word
interface mlr_pix_if #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
);
    logic                                valid;
    logic                                ready;
    logic signed [COORD_BITS-1:0]        pixel_x;
    logic signed [COORD_BITS-1:0]        pixel_y;
    logic        [mlr_pkg::COLOR_BITS-1:0] pixel_color_out;
    logic                                last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, pixel_color_out, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, pixel_color_out, last_pixel,
        output ready
    );
endinterface

/* design/midpoint_line_rasterizer_top.sv */
`timescale 1ns / 1ps

// Channel | Dir | Word                                              | Handshake
// i_req   | in  | req_type, x_start, y_start, x_end, y_end, color   | valid/ready
// o_pix   | out | pixel_x, pixel_y, pixel_color_out, last_pixel     | valid/ready
//
// One request word per cycle while i_req.ready is high; a start word is set up
// by the combinational start setup path (endpoint differences, abs, axis compare, decision init).
// A start or an active advance produces a pixel word in the cycle after acceptance.
// i_req.ready is high when the output register is empty or being drained.
// Synchronous active-low reset clears the line-active flag and the output valid.

module midpoint_line_rasterizer_top #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    mlr_req_if.sink      i_req,
    mlr_pix_if.source    o_pix
);
    import mlr_pkg::*;

    localparam int DW = COORD_BITS + 1;  // endpoint difference
    localparam int W  = COORD_BITS + 3;  // decision term and move increment
    localparam int SW = COORD_BITS + 2;  // stay increment

    // line state
    logic signed [COORD_BITS-1:0] r_cur_x, n_cur_x;
    logic signed [COORD_BITS-1:0] r_cur_y, n_cur_y;
    logic signed [COORD_BITS-1:0] r_major_end, n_major_end;
    logic signed [W-1:0]          r_decision, n_decision;
    logic signed [W-1:0]          r_inc_move, n_inc_move;
    logic        [SW-1:0]         r_inc_stay, n_inc_stay;
    logic                         r_minor_neg, n_minor_neg;
    logic                         r_x_major, n_x_major;
    logic                         r_line_active, n_line_active;
    logic        [COLOR_BITS-1:0] r_color, n_color;

    // output register
    logic                         r_out_valid;
    logic signed [COORD_BITS-1:0] r_out_x;
    logic signed [COORD_BITS-1:0] r_out_y;
    logic        [COLOR_BITS-1:0] r_out_color;
    logic                         r_out_last;

    logic in_acc;
    logic is_start;
    logic produce;

    // start setup
    logic signed [DW-1:0]         s_dx, s_dy, s_raw_minor;
    logic        [COORD_BITS-1:0] s_adx, s_ady, s_dmaj, s_dmin;
    logic                         s_x_major, s_swap, s_minor_neg;
    logic signed [COORD_BITS-1:0] s_ma, s_mb, s_na, s_nb, s_maj0, s_min0;

    // advance
    logic                         a_move;
    logic signed [COORD_BITS-1:0] a_step;
    logic                         e_last;

    assign i_req.ready = !r_out_valid || o_pix.ready;
    assign in_acc      = i_req.valid && i_req.ready;
    assign is_start    = (t_req_type'(i_req.req_type) == REQ_START);
    assign produce     = in_acc && (is_start || r_line_active);

    always_comb begin
        s_dx = $signed({i_req.x_end[COORD_BITS-1], i_req.x_end})
             - $signed({i_req.x_start[COORD_BITS-1], i_req.x_start});
        s_dy = $signed({i_req.y_end[COORD_BITS-1], i_req.y_end})
             - $signed({i_req.y_start[COORD_BITS-1], i_req.y_start});
        s_adx = s_dx[DW-1] ? COORD_BITS'(-s_dx) : COORD_BITS'(s_dx);
        s_ady = s_dy[DW-1] ? COORD_BITS'(-s_dy) : COORD_BITS'(s_dy);
        s_x_major = (s_ady <= s_adx);

        s_ma        = s_x_major ? i_req.x_start : i_req.y_start;
        s_mb        = s_x_major ? i_req.x_end   : i_req.y_end;
        s_na        = s_x_major ? i_req.y_start : i_req.x_start;
        s_nb        = s_x_major ? i_req.y_end   : i_req.x_end;
        s_dmaj      = s_x_major ? s_adx : s_ady;
        s_dmin      = s_x_major ? s_ady : s_adx;
        s_raw_minor = s_x_major ? s_dy : s_dx;
        // endpoints swap when the major coordinate falls; the minor sign flips with it
        s_swap      = s_x_major ? s_dx[DW-1] : s_dy[DW-1];
        s_minor_neg = s_swap ? (!s_raw_minor[DW-1] && (s_raw_minor != '0))
                             : s_raw_minor[DW-1];
        s_maj0      = s_swap ? s_mb : s_ma;
        s_min0      = s_swap ? s_nb : s_na;

        a_move = (r_decision > 0);
        a_step = r_minor_neg ? '1 : COORD_BITS'(1);

        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_major_end = r_major_end;
        n_decision  = r_decision;
        n_inc_move  = r_inc_move;
        n_inc_stay  = r_inc_stay;
        n_minor_neg = r_minor_neg;
        n_x_major   = r_x_major;
        n_color     = r_color;

        if (is_start) begin
            n_x_major   = s_x_major;
            n_minor_neg = s_minor_neg;
            n_major_end = s_swap ? s_ma : s_mb;
            n_cur_x     = s_x_major ? s_maj0 : s_min0;
            n_cur_y     = s_x_major ? s_min0 : s_maj0;
            n_decision  = $signed({2'b00, s_dmin, 1'b0}) - $signed({3'b000, s_dmaj});
            n_inc_move  = $signed({2'b00, s_dmin, 1'b0}) - $signed({2'b00, s_dmaj, 1'b0});
            n_inc_stay  = {1'b0, s_dmin, 1'b0};
            n_color     = i_req.pixel_color;
        end else begin
            n_decision = r_decision + (a_move ? r_inc_move : $signed({1'b0, r_inc_stay}));
            if (r_x_major) begin
                n_cur_x = r_cur_x + COORD_BITS'(1);
                n_cur_y = a_move ? r_cur_y + a_step : r_cur_y;
            end else begin
                n_cur_y = r_cur_y + COORD_BITS'(1);
                n_cur_x = a_move ? r_cur_x + a_step : r_cur_x;
            end
        end

        e_last        = ((n_x_major ? n_cur_x : n_cur_y) == n_major_end);
        n_line_active = !e_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_active <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (produce) begin
                r_line_active <= n_line_active;
            end
            if (in_acc) begin
                r_out_valid <= produce;
            end else if (o_pix.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (produce) begin
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_major_end <= n_major_end;
            r_decision  <= n_decision;
            r_inc_move  <= n_inc_move;
            r_inc_stay  <= n_inc_stay;
            r_minor_neg <= n_minor_neg;
            r_x_major   <= n_x_major;
            r_color     <= n_color;
            r_out_x     <= n_cur_x;
            r_out_y     <= n_cur_y;
            r_out_color <= n_color;
            r_out_last  <= e_last;
        end
    end

    assign o_pix.valid           = r_out_valid;
    assign o_pix.pixel_x         = r_out_x;
    assign o_pix.pixel_y         = r_out_y;
    assign o_pix.pixel_color_out = r_out_color;
    assign o_pix.last_pixel      = r_out_last;

    a_start_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && is_start |=> o_pix.valid)
        else $error("start word gave no pixel");

    a_idle_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !is_start && !r_line_active |=> !o_pix.valid)
        else $error("advance without a line gave a pixel");

    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_last |-> !r_line_active)
        else $error("line still active after last pixel");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_req.ready)
        else $error("request blocked with empty output register");

endmodule
